// ===== design/obsfb_pkg.sv =====
`default_nettype none
package obsfb_pkg;

   localparam int STATE_ORDER = 4;

   localparam int DATA_W  = 32;
   localparam int INDEX_W = 6;
   localparam int LIMIT_W = 31;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd5243;

   localparam int STORE_DEPTH = STATE_ORDER * STATE_ORDER + 6 * STATE_ORDER;
   localparam int COEFF_AW    = $clog2(STORE_DEPTH);

   localparam int BASE_A = 0;
   localparam int BASE_L = STATE_ORDER * STATE_ORDER;
   localparam int BASE_C = STATE_ORDER * STATE_ORDER + 2 * STATE_ORDER;
   localparam int BASE_B = STATE_ORDER * STATE_ORDER + 4 * STATE_ORDER;
   localparam int BASE_K = STATE_ORDER * STATE_ORDER + 5 * STATE_ORDER;

   localparam int ORD_W     = (STATE_ORDER > 1) ? $clog2(STATE_ORDER) : 1;
   localparam int EST_AW    = ORD_W + 1;
   localparam int EST_DEPTH = 2 ** EST_AW;
   localparam int COL_W     = $clog2(STATE_ORDER + 3);

   localparam int PROD_W = 2 * DATA_W - 16;
   localparam int ACC_W  = PROD_W + $clog2(STATE_ORDER + 4);

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INNOV,
      SEQ_EST,
      SEQ_GAIN,
      SEQ_DRAIN,
      SEQ_OUTPUT
   } obsfb_seq_state_type;

   typedef enum logic [1:0] {
      SRC_EST,
      SRC_INNOV,
      SRC_DRIVE
   } obsfb_src_type;

   typedef enum logic [1:0] {
      DST_INNOV,
      DST_EST,
      DST_GAIN
   } obsfb_dst_type;

   typedef struct packed {
      logic              valid;
      obsfb_src_type     src;
      logic              src_k;
      logic              est_zero;
      logic              neg;
      logic              first;
      logic              last;
      obsfb_dst_type     dst;
      logic [ORD_W-1:0]  idx;
   } obsfb_term_type;

   typedef struct packed {
      logic                   busy;
      logic [STATE_ORDER-1:0] est_pend;
   } obsfb_status_type;

   function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] v);
      logic [DATA_W-1:0] r;
      if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
         r = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/obsfb_req_if.sv =====
`default_nettype none
interface obsfb_req_if;
   import obsfb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [INDEX_W-1:0]        coeff_index;
   logic signed [DATA_W-1:0]  coeff_value;
   logic signed [DATA_W-1:0]  velocity_meas;
   logic signed [DATA_W-1:0]  position_meas;
   logic                      move_enable;
   logic                      gain_enable;

   modport source (
      output valid, mode, coeff_index, coeff_value, velocity_meas, position_meas,
             move_enable, gain_enable,
      input  ready
   );

   modport sink (
      input  valid, mode, coeff_index, coeff_value, velocity_meas, position_meas,
             move_enable, gain_enable,
      output ready
   );
endinterface
`default_nettype wire

// ===== design/obsfb_rsp_if.sv =====
`default_nettype none
interface obsfb_rsp_if;
   import obsfb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  drive;
   logic                      saturated;

   modport source (output valid, drive, saturated, input ready);
   modport sink   (input valid, drive, saturated, output ready);
endinterface
`default_nettype wire

// ===== design/observer_state_feedback_axis.sv =====
// one axis of a discrete observer with state feedback, signed q16.16
// req_bus carries two kinds of request, chosen by mode:
//   load   - writes coeff_value into coefficient slot coeff_index (A row-major,
//            then L, C, B, K); slots past the store are dropped
//   sample - velocity/position measurement; updates the estimate and, when
//            move_enable is set, emits one drive on rsp_bus
// a sample takes one multiply-accumulate per cycle, save while a feedback
// term waits for its estimate entry to land, through a single 32x32 multiplier
// fed from the coefficient ram and the estimate ram: 2n + n(n+3) terms, plus
// n feedback terms when move and gain are set, then a pipeline drain and the
// posting of any drive; req_bus.ready is low while a sample is in work
// csr_wr_data sets the drive clip magnitude (reset 0.08 in q16.16)
// reset clears the estimate and the held drive and returns the clip limit
// to 0.08; the coefficient store has no reset and must be loaded first
// a stalled rsp_bus holds the drive in its output register; the next request
// is still taken, and a later drive waits for that register to free up
`default_nettype none
module observer_state_feedback_axis (
   input  wire logic                              clock,
   input  wire logic                              reset,
   obsfb_req_if.sink                              req_bus,
   obsfb_rsp_if.source                            rsp_bus,
   input  wire logic                              csr_wr_en,
   input  wire logic [obsfb_pkg::LIMIT_W-1:0]     csr_wr_data
);
   import obsfb_pkg::*;

   logic [LIMIT_W-1:0]  drive_limit_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_drive_ff;
   logic                rsp_sat_ff;
   logic                seq_idle;
   logic                req_accept;
   logic                sample_go;
   logic                coeff_we;
   logic                rsp_free;
   logic                rsp_load;
   logic                wr_bank;
   logic [COEFF_AW-1:0] coeff_rd_addr;
   logic [DATA_W-1:0]   coeff_rd_data;
   logic [EST_AW-1:0]   est_rd_addr;
   logic [DATA_W-1:0]   est_rd_data;
   logic                est_wr_en;
   logic [EST_AW-1:0]   est_wr_addr;
   logic [DATA_W-1:0]   est_wr_data;
   logic [DATA_W-1:0]   drive_res;
   logic                sat_res;
   obsfb_term_type      term;
   obsfb_status_type    status;

   assign req_bus.ready = seq_idle;
   assign req_accept    = req_bus.valid && seq_idle;
   assign sample_go     = req_accept && req_bus.mode;
   assign coeff_we      = req_accept && !req_bus.mode &&
                          (int'(req_bus.coeff_index) < STORE_DEPTH);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_limit_ff <= LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            drive_limit_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_drive_ff <= drive_res;
         rsp_sat_ff   <= sat_res;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.drive     = rsp_drive_ff;
   assign rsp_bus.saturated = rsp_sat_ff;

   obsfb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_coeff_ram (
      .clock   (clock),
      .wr_en   (coeff_we),
      .wr_addr (COEFF_AW'(req_bus.coeff_index)),
      .wr_data (req_bus.coeff_value),
      .rd_addr (coeff_rd_addr),
      .rd_data (coeff_rd_data)
   );

   obsfb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (EST_DEPTH)
   ) u_est_ram (
      .clock   (clock),
      .wr_en   (est_wr_en),
      .wr_addr (est_wr_addr),
      .wr_data (est_wr_data),
      .rd_addr (est_rd_addr),
      .rd_data (est_rd_data)
   );

   obsfb_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .sample_go     (sample_go),
      .move_enable   (req_bus.move_enable),
      .gain_enable   (req_bus.gain_enable),
      .rsp_free      (rsp_free),
      .status        (status),
      .idle          (seq_idle),
      .rsp_load      (rsp_load),
      .wr_bank       (wr_bank),
      .coeff_rd_addr (coeff_rd_addr),
      .est_rd_addr   (est_rd_addr),
      .term          (term)
   );

   obsfb_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .sample_go     (sample_go),
      .velocity_meas (req_bus.velocity_meas),
      .position_meas (req_bus.position_meas),
      .drive_limit   (drive_limit_ff),
      .term          (term),
      .coeff_rd_data (coeff_rd_data),
      .est_rd_data   (est_rd_data),
      .wr_bank       (wr_bank),
      .rsp_load      (rsp_load),
      .est_wr_en     (est_wr_en),
      .est_wr_addr   (est_wr_addr),
      .est_wr_data   (est_wr_data),
      .status        (status),
      .drive_res     (drive_res),
      .sat_res       (sat_res)
   );

   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !rsp_load)
      else $error("pending drive overwritten");

endmodule
`default_nettype wire

// ===== design/obsfb_ram.sv =====
`default_nettype none
module obsfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== design/obsfb_seq.sv =====
`default_nettype none
module obsfb_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          sample_go,
   input  wire logic                          move_enable,
   input  wire logic                          gain_enable,
   input  wire logic                          rsp_free,
   input  wire obsfb_pkg::obsfb_status_type   status,
   output logic                               idle,
   output logic                               rsp_load,
   output logic                               wr_bank,
   output logic [obsfb_pkg::COEFF_AW-1:0]     coeff_rd_addr,
   output logic [obsfb_pkg::EST_AW-1:0]       est_rd_addr,
   output obsfb_pkg::obsfb_term_type          term
);
   import obsfb_pkg::*;

   obsfb_seq_state_type state_ff, state_in;
   logic [ORD_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             move_ff, move_in;
   logic             gain_ff, gain_in;
   logic             bank_ff, bank_in;
   logic             init_ff, init_in;
   logic             gain_stall;
   logic             row_end_innov;
   logic             row_end_est;
   logic             col_end_ord;
   logic             col_end_est;

   assign col_end_ord   = (col_ff == COL_W'(STATE_ORDER - 1));
   assign col_end_est   = (col_ff == COL_W'(STATE_ORDER + 2));
   assign row_end_innov = (row_ff == ORD_W'(1));
   assign row_end_est   = (row_ff == ORD_W'(STATE_ORDER - 1));
   // hold the feedback read until the new estimate entry has landed in the ram
   assign gain_stall    = status.est_pend[col_ff[ORD_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         move_ff  <= 1'b0;
         gain_ff  <= 1'b0;
         bank_ff  <= 1'b0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         move_ff  <= move_in;
         gain_ff  <= gain_in;
         bank_ff  <= bank_in;
         init_ff  <= init_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      move_in  = move_ff;
      gain_in  = gain_ff;
      bank_in  = bank_ff;
      init_in  = init_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (sample_go) begin
               state_in = SEQ_INNOV;
               row_in   = '0;
               col_in   = '0;
               move_in  = move_enable;
               gain_in  = gain_enable;
            end
         end
         SEQ_INNOV: begin
            if (col_end_ord) begin
               col_in = '0;
               if (row_end_innov) begin
                  row_in   = '0;
                  state_in = SEQ_EST;
               end else begin
                  row_in = row_ff + ORD_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         SEQ_EST: begin
            if (col_end_est) begin
               col_in = '0;
               if (row_end_est) begin
                  row_in   = '0;
                  state_in = (move_ff && gain_ff) ? SEQ_GAIN : SEQ_DRAIN;
               end else begin
                  row_in = row_ff + ORD_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         SEQ_GAIN: begin
            if (!gain_stall) begin
               if (col_end_ord) begin
                  col_in   = '0;
                  state_in = SEQ_DRAIN;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         SEQ_DRAIN: begin
            if (!status.busy) begin
               bank_in  = ~bank_ff;
               init_in  = 1'b1;
               state_in = move_ff ? SEQ_OUTPUT : SEQ_IDLE;
            end
         end
         SEQ_OUTPUT: begin
            if (rsp_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      idle          = 1'b0;
      rsp_load      = 1'b0;
      coeff_rd_addr = '0;
      est_rd_addr   = {bank_ff, col_ff[ORD_W-1:0]};
      term          = '0;
      term.src      = SRC_EST;
      term.dst      = DST_INNOV;
      case (state_ff)
         SEQ_IDLE: begin
            idle = 1'b1;
         end
         SEQ_INNOV: begin
            coeff_rd_addr = COEFF_AW'(BASE_C + int'(row_ff) * STATE_ORDER + int'(col_ff));
            term.valid    = 1'b1;
            term.est_zero = !init_ff;
            term.neg      = 1'b1;
            term.first    = (col_ff == '0);
            term.last     = col_end_ord;
            term.idx      = row_ff;
         end
         SEQ_EST: begin
            term.valid = 1'b1;
            term.first = (col_ff == '0);
            term.last  = col_end_est;
            term.dst   = DST_EST;
            term.idx   = row_ff;
            if (col_ff < COL_W'(STATE_ORDER)) begin
               coeff_rd_addr = COEFF_AW'(BASE_A + int'(row_ff) * STATE_ORDER + int'(col_ff));
               term.est_zero = !init_ff;
            end else if (col_ff == COL_W'(STATE_ORDER)) begin
               coeff_rd_addr = COEFF_AW'(BASE_B + int'(row_ff));
               term.src      = SRC_DRIVE;
            end else begin
               term.src      = SRC_INNOV;
               term.src_k    = col_end_est;
               coeff_rd_addr = COEFF_AW'(BASE_L + int'(row_ff) * 2 + int'(col_end_est));
            end
         end
         SEQ_GAIN: begin
            // feedback reads the freshly written bank
            coeff_rd_addr = COEFF_AW'(BASE_K + int'(col_ff));
            est_rd_addr   = {~bank_ff, col_ff[ORD_W-1:0]};
            term.valid    = !gain_stall;
            term.first    = (col_ff == '0);
            term.last     = col_end_ord;
            term.dst      = DST_GAIN;
         end
         SEQ_DRAIN: begin
         end
         SEQ_OUTPUT: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign wr_bank = ~bank_ff;

   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_DRAIN && !status.busy) |=> (bank_ff != $past(bank_ff) && init_ff))
      else $error("estimate bank did not flip at end of sample");

   a_load_move: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (move_ff && !status.busy))
      else $error("drive emitted without motion enabled or with work in flight");

endmodule
`default_nettype wire

// ===== design/obsfb_mac.sv =====
`default_nettype none
module obsfb_mac (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               sample_go,
   input  wire logic        [obsfb_pkg::DATA_W-1:0] velocity_meas,
   input  wire logic        [obsfb_pkg::DATA_W-1:0] position_meas,
   input  wire logic        [obsfb_pkg::LIMIT_W-1:0] drive_limit,
   input  wire obsfb_pkg::obsfb_term_type          term,
   input  wire logic        [obsfb_pkg::DATA_W-1:0] coeff_rd_data,
   input  wire logic        [obsfb_pkg::DATA_W-1:0] est_rd_data,
   input  wire logic                               wr_bank,
   input  wire logic                               rsp_load,
   output logic                                    est_wr_en,
   output logic             [obsfb_pkg::EST_AW-1:0] est_wr_addr,
   output logic             [obsfb_pkg::DATA_W-1:0] est_wr_data,
   output obsfb_pkg::obsfb_status_type             status,
   output logic             [obsfb_pkg::DATA_W-1:0] drive_res,
   output logic                                    sat_res
);
   import obsfb_pkg::*;

   obsfb_term_type s1_ff, s2_ff, s3_ff;
   logic [DATA_W-1:0]        y0_ff, y1_ff;
   logic [DATA_W-1:0]        innov_ff [2];
   logic [DATA_W-1:0]        last_drive_ff;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [DATA_W-1:0]        drive_res_ff, drive_res_in;
   logic                     sat_res_ff, sat_res_in;
   logic [DATA_W-1:0]        operand;
   logic signed [2*DATA_W-1:0] prod_full;
   logic [ACC_W-1:0]         base;
   logic [ACC_W-1:0]         prod_ext;
   logic [DATA_W-1:0]        y_sel;
   logic [DATA_W-1:0]        sum_sat;
   logic signed [DATA_W:0]   u_raw;
   logic signed [DATA_W:0]   lim_pos;
   logic signed [DATA_W:0]   lim_neg;
   logic signed [DATA_W:0]   u_clip;
   logic                     u_hit;
   logic                     s3_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff         <= '0;
         s2_ff         <= '0;
         s3_ff         <= '0;
         last_drive_ff <= '0;
      end else begin
         s1_ff <= term;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         if (rsp_load) begin
            last_drive_ff <= drive_res_ff;
         end
      end
   end

   // operand select and multiply, ram data arrives in the cycle after issue
   always_comb begin
      case (s1_ff.src)
         SRC_EST:   operand = s1_ff.est_zero ? '0 : est_rd_data;
         SRC_INNOV: operand = innov_ff[s1_ff.src_k];
         SRC_DRIVE: operand = last_drive_ff;
         default:   operand = '0;
      endcase
      prod_full = $signed(coeff_rd_data) * $signed(operand);
      prod_in   = prod_full[2*DATA_W-1:16];
   end

   // accumulate, an innovation sum starts from the measurement
   always_comb begin
      y_sel    = s2_ff.idx[0] ? y1_ff : y0_ff;
      prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (s2_ff.first) begin
         base = (s2_ff.dst == DST_INNOV) ? {{(ACC_W-DATA_W){y_sel[DATA_W-1]}}, y_sel} : '0;
      end else begin
         base = acc_ff;
      end
      acc_in = s2_ff.neg ? (base - prod_ext) : (base + prod_ext);
   end

   always_comb begin
      s3_done = s3_ff.valid && s3_ff.last;
      sum_sat = sat32(acc_ff);
      u_raw   = -$signed({sum_sat[DATA_W-1], sum_sat});
      lim_pos = $signed({2'b00, drive_limit});
      lim_neg = -lim_pos;
      u_clip  = u_raw;
      u_hit   = 1'b0;
      if (u_raw > lim_pos) begin
         u_clip = lim_pos;
         u_hit  = 1'b1;
      end else if (u_raw < lim_neg) begin
         u_clip = lim_neg;
         u_hit  = 1'b1;
      end
      drive_res_in = drive_res_ff;
      sat_res_in   = sat_res_ff;
      if (sample_go) begin
         drive_res_in = '0;
         sat_res_in   = 1'b0;
      end else if (s3_done && s3_ff.dst == DST_GAIN) begin
         drive_res_in = u_clip[DATA_W-1:0];
         sat_res_in   = u_hit;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      drive_res_ff <= drive_res_in;
      sat_res_ff   <= sat_res_in;
      if (s2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (sample_go) begin
         y0_ff <= velocity_meas;
         y1_ff <= position_meas;
      end
      if (s3_done && s3_ff.dst == DST_INNOV) begin
         innov_ff[s3_ff.idx[0]] <= sum_sat;
      end
   end

   assign est_wr_en   = s3_done && (s3_ff.dst == DST_EST);
   assign est_wr_addr = {wr_bank, s3_ff.idx};
   assign est_wr_data = sum_sat;

   always_comb begin
      status.busy = s1_ff.valid || s2_ff.valid || s3_ff.valid;
      for (int j = 0; j < STATE_ORDER; j++) begin
         status.est_pend[j] =
            (s1_ff.valid && s1_ff.dst == DST_EST && s1_ff.idx == ORD_W'(j)) ||
            (s2_ff.valid && s2_ff.dst == DST_EST && s2_ff.idx == ORD_W'(j)) ||
            (s3_ff.valid && s3_ff.dst == DST_EST && s3_ff.idx == ORD_W'(j));
      end
   end

   assign drive_res = drive_res_ff;
   assign sat_res   = sat_res_ff;

   a_drive_in_limit: assert property (@(posedge clock) disable iff (reset)
      (s3_done && s3_ff.dst == DST_GAIN) |=>
         ($signed({drive_res_ff[DATA_W-1], drive_res_ff}) <= lim_pos &&
          $signed({drive_res_ff[DATA_W-1], drive_res_ff}) >= lim_neg))
      else $error("drive outside the clip limit");

endmodule
`default_nettype wire
